/* rtl/sbl_pkg.sv */
// Package: shared constants, payload types and register codes for the sprite blitter.
`default_nettype none
package sbl_pkg;

  localparam int WRAP_WIDTH = 8352;
  localparam int WRAP_HI    = 'h1051;
  localparam int WRAP_LO    = -'h1050;
  localparam int ADDR_BITS  = 24;
  localparam int OUT_AW     = 24;
  localparam int SPR_W      = 12;
  localparam int STRIDE_W   = 14;
  localparam int GW         = 20;
  localparam int PW         = GW + STRIDE_W + 1;
  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
  localparam int GEOM_STAGES = 8;
  localparam int CFG_IDX_W  = 3;

  typedef logic signed [GW-1:0] g_t;
  typedef logic signed [PW-1:0] p_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_XMIN     = 3'd0,
    CFG_CLIP_TOP      = 3'd1,
    CFG_CLIP_RIGHT    = 3'd2,
    CFG_CLIP_BOTTOM   = 3'd3,
    CFG_VIEWPORT_LEFT = 3'd4,
    CFG_VIEWPORT_TOP  = 3'd5,
    CFG_ROW_PITCH     = 3'd6,
    CFG_COPY_ZERO     = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic signed [15:0]    clip_xmin;
    logic signed [15:0]    clip_top;
    logic signed [15:0]    clip_right;
    logic signed [15:0]    clip_bottom;
    logic signed [15:0]    viewport_left;
    logic signed [15:0]    viewport_top;
    logic [STRIDE_W-1:0]   row_pitch;
    logic                  copy_zero_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0]          pixel;
    logic                first_pixel;
    logic [SPR_W-1:0]    sprite_width;
    logic [SPR_W-1:0]    sprite_height;
    logic signed [15:0]  world_x;
    logic signed [15:0]  world_y;
  } in_t;

  typedef struct packed {
    logic [7:0]            pixel;
    logic                  first;
    logic [SPR_W-1:0]      width;
    logic [SPR_W-1:0]      col_start;
    logic [SPR_W-1:0]      col_end;
    logic [SPR_W-1:0]      row_start;
    logic [SPR_W-1:0]      row_end;
    logic [ADDR_BITS-1:0]  base;
    logic                  visible;
  } geom_t;

  typedef struct packed {
    logic [OUT_AW-1:0] write_address;
    logic [7:0]        write_pixel;
  } out_t;

endpackage
`default_nettype wire

/* rtl/sbl_pix_if.sv */
// Interface: source pixel channel with sprite geometry fields.
`default_nettype none
interface sbl_pix_if;
  import sbl_pkg::*;
  logic                valid;
  logic                ready;
  logic [7:0]          pixel;
  logic                first_pixel;
  logic [SPR_W-1:0]    sprite_width;
  logic [SPR_W-1:0]    sprite_height;
  logic signed [15:0]  world_x;
  logic signed [15:0]  world_y;

  modport source (output valid, pixel, first_pixel, sprite_width, sprite_height,
                  world_x, world_y, input ready);
  modport sink (input valid, pixel, first_pixel, sprite_width, sprite_height,
                world_x, world_y, output ready);
endinterface
`default_nettype wire

/* rtl/sbl_wr_if.sv */
// Interface: frame-buffer write channel.
`default_nettype none
interface sbl_wr_if;
  import sbl_pkg::*;
  logic              valid;
  logic              ready;
  logic [OUT_AW-1:0] write_address;
  logic [7:0]        write_pixel;

  modport source (output valid, write_address, write_pixel, input ready);
  modport sink (input valid, write_address, write_pixel, output ready);
endinterface
`default_nettype wire

/* rtl/sbl_cfg_if.sv */
// Interface: configuration register write channel.
`default_nettype none
interface sbl_cfg_if;
  import sbl_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/sbl_geom.sv */
// Geometry pipeline: wrap, clip and viewport mapping, row base address per pixel.
`default_nettype none
module sbl_geom (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  sbl_pkg::in_t  item,
  input  sbl_pkg::cfg_t cfg,
  output logic          geom_valid,
  output sbl_pkg::geom_t geom
);
  import sbl_pkg::*;

  typedef struct packed {
    logic [7:0]       pixel;
    logic             first;
    logic [SPR_W-1:0] width;
  } carry_t;

  logic [GEOM_STAGES-1:0] vld;

  in_t    i0;
  carry_t c1, c2, c3, c4, c5, c6;
  g_t rel1, ty1, mx1, my1, vx1, vy1, sr1, sb1;
  g_t tx2, ty2, db2, mx2, my2, vx2, vy2, sr2, sb2;
  logic rej3;
  g_t sx3, sy3, tx3, ty3, srl3, sbl3, sr3, sb3, vx3, vy3;
  logic rej4;
  g_t sx4, sy4, sr4, sb4, tx4, ty4;
  logic vis5;
  logic [SPR_W-1:0] cs5, ce5, rs5, re5;
  g_t tx5, ty5;
  logic vis6;
  logic [SPR_W-1:0] cs6, ce6, rs6, re6;
  p_t prod6;
  g_t tx6;

  g_t wrap_x, dr_x, tx_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[GEOM_STAGES-2:0], accept};
    end
  end

  always_comb begin
    if (rel1 >= g_t'(WRAP_HI)) begin
      wrap_x = rel1 - g_t'(WRAP_WIDTH);
    end else if (rel1 < g_t'(WRAP_LO)) begin
      wrap_x = rel1 + g_t'(WRAP_WIDTH);
    end else begin
      wrap_x = rel1;
    end
    dr_x   = sr2 + tx2;
    tx_pos = tx4[GW-1] ? tx4 + g_t'(WRAP_WIDTH) : tx4;
  end

  always_ff @(posedge clk) begin
    i0 <= item;

    c1   <= '{pixel: i0.pixel, first: i0.first_pixel, width: i0.sprite_width};
    rel1 <= g_t'(i0.world_x) - g_t'(cfg.clip_xmin);
    ty1  <= g_t'(i0.world_y) - g_t'(cfg.clip_top);
    mx1  <= g_t'(cfg.clip_right) - g_t'(cfg.clip_xmin) - g_t'(1);
    my1  <= g_t'(cfg.clip_bottom) - g_t'(cfg.clip_top) - g_t'(1);
    vx1  <= g_t'(cfg.clip_xmin) - g_t'(cfg.viewport_left);
    vy1  <= g_t'(cfg.clip_top) - g_t'(cfg.viewport_top);
    sr1  <= g_t'(i0.sprite_width) - g_t'(1);
    sb1  <= g_t'(i0.sprite_height) - g_t'(1);

    c2  <= c1;
    tx2 <= wrap_x;
    ty2 <= ty1;
    db2 <= sb1 + ty1;
    mx2 <= mx1;
    my2 <= my1;
    vx2 <= vx1;
    vy2 <= vy1;
    sr2 <= sr1;
    sb2 <= sb1;

    c3   <= c2;
    rej3 <= (tx2 > mx2) || (ty2 > my2) || dr_x[GW-1] || db2[GW-1];
    sx3  <= tx2[GW-1] ? -tx2 : '0;
    tx3  <= tx2[GW-1] ? '0 : tx2;
    sy3  <= ty2[GW-1] ? -ty2 : '0;
    ty3  <= ty2[GW-1] ? '0 : ty2;
    srl3 <= mx2 - tx2;
    sbl3 <= my2 - ty2;
    sr3  <= sr2;
    sb3  <= sb2;
    vx3  <= vx2;
    vy3  <= vy2;

    c4   <= c3;
    rej4 <= rej3;
    sx4  <= sx3;
    sy4  <= sy3;
    sr4  <= (sr3 < srl3) ? sr3 : srl3;
    sb4  <= (sb3 < sbl3) ? sb3 : sbl3;
    tx4  <= tx3 + vx3;
    ty4  <= ty3 + vy3;

    c5   <= c4;
    vis5 <= !rej4 && (sr4 >= sx4) && (sb4 >= sy4);
    cs5  <= sx4[SPR_W-1:0];
    ce5  <= sr4[SPR_W-1:0];
    rs5  <= sy4[SPR_W-1:0];
    re5  <= sb4[SPR_W-1:0];
    tx5  <= tx_pos;
    ty5  <= ty4;

    c6    <= c5;
    vis6  <= vis5;
    cs6   <= cs5;
    ce6   <= ce5;
    rs6   <= rs5;
    re6   <= re5;
    prod6 <= p_t'(ty5) * p_t'($signed({1'b0, cfg.row_pitch}));
    tx6   <= tx5;

    geom.pixel     <= c6.pixel;
    geom.first     <= c6.first;
    geom.width     <= c6.width;
    geom.col_start <= cs6;
    geom.col_end   <= ce6;
    geom.row_start <= rs6;
    geom.row_end   <= re6;
    geom.visible   <= vis6;
    geom.base      <= ADDR_BITS'(prod6 + p_t'(tx6));
  end

  assign geom_valid = vld[GEOM_STAGES-1];

endmodule
`default_nettype wire

/* rtl/sbl_emit.sv */
// Pixel stage: source column/row counters, window test, color key and write address.
`default_nettype none
module sbl_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           geom_valid,
  input  sbl_pkg::geom_t geom,
  input  sbl_pkg::cfg_t  cfg,
  output logic           push,
  output logic           retire,
  output sbl_pkg::out_t  wr_data
);
  import sbl_pkg::*;

  logic [SPR_W-1:0]     lw, cc, rc, cs, ce, rs, re;
  logic [ADDR_BITS-1:0] base;
  logic                 vis;

  logic [SPR_W-1:0]     lw_e, cc_e, rc_e, cs_e, ce_e, rs_e, re_e;
  logic [ADDR_BITS-1:0] base_e;
  logic                 vis_e, in_row, row_done;
  logic [SPR_W-1:0]     cc_inc, cc_next, rc_next;
  logic [ADDR_BITS-1:0] base_next;

  always_comb begin
    lw_e   = geom.first ? geom.width     : lw;
    cc_e   = geom.first ? '0             : cc;
    rc_e   = geom.first ? '0             : rc;
    cs_e   = geom.first ? geom.col_start : cs;
    ce_e   = geom.first ? geom.col_end   : ce;
    rs_e   = geom.first ? geom.row_start : rs;
    re_e   = geom.first ? geom.row_end   : re;
    base_e = geom.first ? geom.base      : base;
    vis_e  = geom.first ? geom.visible   : vis;

    in_row = vis_e && (rc_e >= rs_e) && (rc_e <= re_e);
    push   = geom_valid && in_row && (cc_e >= cs_e) && (cc_e <= ce_e) &&
             ((geom.pixel != 8'd0) || cfg.copy_zero_mode);
    retire = geom_valid && !push;

    wr_data.write_address = OUT_AW'(base_e + ADDR_BITS'(cc_e - cs_e));
    wr_data.write_pixel   = geom.pixel;

    cc_inc    = cc_e + SPR_W'(1);
    row_done  = (cc_inc == lw_e);
    cc_next   = row_done ? '0 : cc_inc;
    rc_next   = (row_done && (rc_e != '1)) ? rc_e + SPR_W'(1) : rc_e;
    base_next = (row_done && in_row) ? base_e + ADDR_BITS'(cfg.row_pitch) : base_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw   <= '0;
      cc   <= '0;
      rc   <= '0;
      cs   <= '0;
      ce   <= '0;
      rs   <= '0;
      re   <= '0;
      base <= '0;
      vis  <= 1'b0;
    end else if (geom_valid) begin
      lw   <= lw_e;
      cc   <= cc_next;
      rc   <= rc_next;
      cs   <= cs_e;
      ce   <= ce_e;
      rs   <= rs_e;
      re   <= re_e;
      base <= base_next;
      vis  <= vis_e;
    end
  end

endmodule
`default_nettype wire

/* rtl/sbl_fifo.sv */
// Output queue: holds finished frame-buffer writes until the receiver takes them.
`default_nettype none
module sbl_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sbl_pkg::out_t push_data,
  input  logic          pop,
  output logic          not_empty,
  output sbl_pkg::out_t head
);
  import sbl_pkg::*;

  out_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

endmodule
`default_nettype wire

/* rtl/clipped_color_key_sprite_blit_core.sv */
// Top level: clipped, color-keyed sprite blitter with config registers and output queue.
//
// Channels: pixels (sink) takes one source pixel per transfer in raster order; a transfer
// with first_pixel set also loads sprite size and world position. writes (source) gives
// one frame-buffer write (write_address, write_pixel) per kept, non-transparent pixel.
// cfg (sink) writes registers by index; it is always ready and must only be used while
// no pixel is in flight.
// Throughput: one pixel per cycle while pixels.ready is high. A pixel reaches writes through
// the 8-stage geometry pipeline (input, wrap, clip, viewport map, row-times-stride multiply,
// base add), whose input stage loads at the transfer edge, and then the queue write; the pixel
// counter stage is combinational into the queue.
// A 16-entry output queue with a credit count gates pixels.ready: the source is held
// off only when queued writes plus pixels in flight would fill it, so a stalled
// receiver back-pressures after at most 16 outstanding pixels.
// Reset (rst, synchronous): registers return to defaults (clip 0,0..640,480, viewport
// 0,0, stride 640, zero transparent), the sprite is invisible, the queue is empty.
`default_nettype none
module clipped_color_key_sprite_blit_core (
  input  logic      clk,
  input  logic      rst,
  sbl_pix_if.sink   pixels,
  sbl_wr_if.source  writes,
  sbl_cfg_if.sink   cfg
);
  import sbl_pkg::*;

  cfg_t             regs;
  in_t              item;
  logic             accept, pop, push, retire, geom_valid, q_valid;
  geom_t            geom;
  out_t             wr_data, head;
  logic [CNT_W-1:0] used;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.clip_xmin      <= 16'sd0;
      regs.clip_top       <= 16'sd0;
      regs.clip_right     <= 16'sd640;
      regs.clip_bottom    <= 16'sd480;
      regs.viewport_left  <= 16'sd0;
      regs.viewport_top   <= 16'sd0;
      regs.row_pitch      <= STRIDE_W'(640);
      regs.copy_zero_mode <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg_idx_e'(cfg.index))
        CFG_CLIP_XMIN:     regs.clip_xmin      <= cfg.data;
        CFG_CLIP_TOP:      regs.clip_top       <= cfg.data;
        CFG_CLIP_RIGHT:    regs.clip_right     <= cfg.data;
        CFG_CLIP_BOTTOM:   regs.clip_bottom    <= cfg.data;
        CFG_VIEWPORT_LEFT: regs.viewport_left  <= cfg.data;
        CFG_VIEWPORT_TOP:  regs.viewport_top   <= cfg.data;
        CFG_ROW_PITCH:     regs.row_pitch      <= cfg.data[STRIDE_W-1:0];
        CFG_COPY_ZERO:     regs.copy_zero_mode <= cfg.data[0];
        default: ;
      endcase
    end
  end

  assign cfg.ready = 1'b1;

  assign item.pixel         = pixels.pixel;
  assign item.first_pixel   = pixels.first_pixel;
  assign item.sprite_width  = pixels.sprite_width;
  assign item.sprite_height = pixels.sprite_height;
  assign item.world_x       = pixels.world_x;
  assign item.world_y       = pixels.world_y;

  assign pixels.ready = (used < CNT_W'(FIFO_DEPTH));
  assign accept       = pixels.valid && pixels.ready;
  assign pop          = writes.valid && writes.ready;

  // credits: pixels in flight plus queued writes
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + CNT_W'(accept) - CNT_W'(retire) - CNT_W'(pop);
    end
  end

  sbl_geom u_geom (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (item),
    .cfg        (regs),
    .geom_valid (geom_valid),
    .geom       (geom)
  );

  sbl_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .geom_valid (geom_valid),
    .geom       (geom),
    .cfg        (regs),
    .push       (push),
    .retire     (retire),
    .wr_data    (wr_data)
  );

  sbl_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (wr_data),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (head)
  );

  assign writes.valid         = q_valid;
  assign writes.write_address = head.write_address;
  assign writes.write_pixel   = head.write_pixel;

endmodule
`default_nettype wire

/* rtl/sbl_checker.sv */
// Checker: port-level properties of the sprite blitter, bound to the top level.
`default_nettype none
module sbl_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_ready,
  input logic                      cfg_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [sbl_pkg::OUT_AW-1:0] out_addr,
  input logic [7:0]                out_pixel
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("write channel valid right after reset");

  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready && cfg_ready)
    else $error("pixel or config channel not ready after reset");

  a_min_latency: assert property (@(posedge clk)
    rst |=> !out_valid ##1 !out_valid ##1 !out_valid)
    else $error("write produced faster than the pipeline allows");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_addr) && $stable(out_pixel))
    else $error("stalled write changed or dropped");

endmodule

bind clipped_color_key_sprite_blit_core sbl_checker u_sbl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pixels.ready),
  .cfg_ready (cfg.ready),
  .out_valid (writes.valid),
  .out_ready (writes.ready),
  .out_addr  (writes.write_address),
  .out_pixel (writes.write_pixel)
);
`default_nettype wire
